@@ hdl/lsw_pkg.sv @@
// Shared types, constants and helpers of the LRU sector write buffer.
package lsw_pkg;

    localparam int unsigned SECTORS_PER_PAGE = 4;
    localparam int unsigned MAX_WRITE_BACKS  = 4;
    localparam logic [3:0]  PAGE_BITS        = 4'hF;
    localparam logic [8:0]  CAP_RESET        = 9'd256;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;
    localparam logic KIND_WB   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] page;
        logic [3:0]  sector_mask;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] result_page;
        logic [3:0]  result_mask;
        logic [2:0]  hit_count;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] page;
        logic [3:0]  sectors;
    } entry_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } emit_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_DISPATCH,
        S_SHIFT,
        S_WRFRONT,
        S_EV_RD,
        S_EV_EMIT,
        S_MISS_LOOP,
        S_MISS_FULL,
        S_MISS_INS,
        S_SECT,
        S_SECT_ADD,
        S_FINAL
    } state_t;

    function automatic logic [2:0] popcnt4(input logic [3:0] v);
        return {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
    endfunction

endpackage

@@ hdl/lsw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lsw_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ hdl/lsw_core.sv @@
// Sequencer of the buffer: LRU-ordered entry RAM, lookup, reorder and eviction.
module lsw_core #(
    parameter int ENTRIES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lsw_pkg::in_item_t item,
    input  logic [8:0]       cap,
    output logic             ready,
    output lsw_pkg::emit_t   emit,
    input  logic             emit_ok
);
    import lsw_pkg::*;

    localparam int AW    = $clog2(ENTRIES);
    localparam int NW    = $clog2(ENTRIES + 1);
    localparam int HW    = $clog2(ENTRIES * SECTORS_PER_PAGE + 1);
    localparam int CMP_W = (HW > 9) ? HW : 9;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    in_item_t       item_reg, item_next;
    entry_t         ent_reg, ent_next;
    logic [AW-1:0]  pos_reg, pos_next;
    logic           found_reg, found_next;
    logic [NW-1:0]  cnt_reg, cnt_next;
    logic [HW-1:0]  held_reg, held_next;
    logic [NW-1:0]  scan_reg, scan_next;
    logic           rd_live_reg, rd_live_next;
    logic [AW-1:0]  rd_idx_reg, rd_idx_next;
    logic [AW-1:0]  ev_addr_reg, ev_addr_next;
    logic [2:0]     k_reg, k_next;
    logic [2:0]     need_reg, need_next;
    logic [2:0]     hits_reg, hits_next;
    logic [3:0]     rmask_reg, rmask_next;
    logic [2:0]     sec_reg, sec_next;

    // RAM port
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        ram_wdata, rd_data;

    lsw_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // shared decode
    logic [3:0]     req;
    logic           rd_match, scan_end, is_tail, s_done, cur_bit, held_bit;
    logic           k_room, can_ev_hit;
    logic [NW-1:0]  cnt_m1, cnt_m2;
    logic [3:0]     look_sec;
    logic [2:0]     rd_hits, req_cnt, ev_sz;
    logic [CMP_W-1:0] held_ext, cap_ext, freeb;

    assign req        = item_reg.sector_mask & PAGE_BITS;
    assign rd_match   = rd_live_reg && (rd_data.page == item_reg.page);
    assign scan_end   = (scan_reg == cnt_reg);
    assign cnt_m1     = NW'(cnt_reg - NW'(1));
    assign cnt_m2     = NW'(cnt_reg - NW'(2));
    assign is_tail    = (NW'(pos_reg) == cnt_m1);
    assign s_done     = (sec_reg == 3'(SECTORS_PER_PAGE));
    assign cur_bit    = req[sec_reg[1:0]];
    assign held_bit   = ent_reg.sectors[sec_reg[1:0]];
    assign k_room     = (k_reg < 3'(MAX_WRITE_BACKS));
    assign held_ext   = CMP_W'(held_reg);
    assign cap_ext    = CMP_W'(cap);
    assign can_ev_hit = (held_ext >= cap_ext) && (cnt_reg >= NW'(2)) && k_room;
    assign look_sec   = found_reg ? ent_reg.sectors : 4'h0;
    assign rd_hits    = popcnt4(req & look_sec);
    assign req_cnt    = popcnt4(req);
    assign ev_sz      = popcnt4(rd_data.sectors);
    assign freeb      = (cap_ext > held_ext) ? CMP_W'(cap_ext - held_ext) : '0;
    assign ready      = (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (rd_match || (scan_end && !rd_live_reg))
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (item_reg.command == CMD_READ)
                begin
                    if (found_reg && rd_hits != 3'd0 && pos_reg != '0)
                    begin
                        state_next = S_SHIFT;
                        ret_next   = S_WRFRONT;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
                else if (req == 4'h0)
                begin
                    state_next = S_FINAL;
                end
                else if (!found_reg)
                begin
                    state_next = S_MISS_LOOP;
                end
                else
                begin
                    state_next = S_SECT;
                end
            end
            S_SHIFT:
            begin
                if (scan_reg == '0 && !rd_live_reg)
                begin
                    state_next = ret_reg;
                end
            end
            S_WRFRONT:
            begin
                state_next = S_FINAL;
            end
            S_EV_RD:
            begin
                state_next = S_EV_EMIT;
            end
            S_EV_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ret_reg;
                end
            end
            S_MISS_LOOP:
            begin
                if (need_reg != 3'd0 && cnt_reg != '0 && k_room)
                begin
                    state_next = S_EV_RD;
                    ret_next   = S_MISS_LOOP;
                end
                else
                begin
                    state_next = S_MISS_FULL;
                end
            end
            S_MISS_FULL:
            begin
                state_next = S_MISS_INS;
                if (cnt_reg == NW'(ENTRIES) && k_room)
                begin
                    state_next = S_EV_RD;
                    ret_next   = S_MISS_INS;
                end
            end
            S_MISS_INS:
            begin
                if (cnt_reg == NW'(ENTRIES))
                begin
                    state_next = S_FINAL;
                end
                else if (cnt_reg != '0)
                begin
                    state_next = S_SHIFT;
                    ret_next   = S_WRFRONT;
                end
                else
                begin
                    state_next = S_WRFRONT;
                end
            end
            S_SECT:
            begin
                if (s_done)
                begin
                    state_next = S_WRFRONT;
                end
                else if (cur_bit && held_bit && pos_reg != '0)
                begin
                    state_next = S_SHIFT;
                    ret_next   = S_SECT;
                end
                else if (cur_bit && !held_bit)
                begin
                    state_next = can_ev_hit ? S_EV_RD : S_SECT_ADD;
                    ret_next   = S_SECT_ADD;
                end
            end
            S_SECT_ADD:
            begin
                state_next = S_SECT;
                if (pos_reg != '0)
                begin
                    state_next = S_SHIFT;
                    ret_next   = S_SECT;
                end
            end
            S_FINAL:
            begin
                if (emit_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        item_next    = item_reg;
        ent_next     = ent_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        cnt_next     = cnt_reg;
        held_next    = held_reg;
        scan_next    = scan_reg;
        rd_live_next = 1'b0;
        rd_idx_next  = rd_idx_reg;
        ev_addr_next = ev_addr_reg;
        k_next       = k_reg;
        need_next    = need_reg;
        hits_next    = hits_reg;
        rmask_next   = rmask_reg;
        sec_next     = sec_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = ent_reg;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        emit         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    scan_next  = '0;
                    k_next     = '0;
                    hits_next  = '0;
                    rmask_next = '0;
                    found_next = 1'b0;
                end
            end
            S_SEARCH:
            begin
                if (rd_match)
                begin
                    found_next = 1'b1;
                    pos_next   = rd_idx_reg;
                    ent_next   = rd_data;
                end
                else if (!scan_end)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = scan_reg[AW-1:0];
                    rd_live_next = 1'b1;
                    rd_idx_next  = scan_reg[AW-1:0];
                    scan_next    = NW'(scan_reg + NW'(1));
                end
            end
            S_DISPATCH:
            begin
                scan_next = NW'(pos_reg);
                if (item_reg.command == CMD_READ)
                begin
                    hits_next  = rd_hits;
                    rmask_next = req & ~look_sec;
                end
                else
                begin
                    sec_next  = '0;
                    need_next = (CMP_W'(req_cnt) > freeb) ? 3'(CMP_W'(req_cnt) - freeb) : 3'd0;
                end
            end
            S_SHIFT:
            begin
                // moves entries [0 .. scan-1] down one place, last first
                if (scan_reg != '0)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = AW'(scan_reg - NW'(1));
                    rd_live_next = 1'b1;
                    rd_idx_next  = AW'(scan_reg - NW'(1));
                    scan_next    = NW'(scan_reg - NW'(1));
                end
                if (rd_live_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(rd_idx_reg + AW'(1));
                    ram_wdata = rd_data;
                end
                if (scan_reg == '0 && !rd_live_reg)
                begin
                    pos_next = '0;
                end
            end
            S_WRFRONT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = ent_reg;
            end
            S_EV_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = ev_addr_reg;
            end
            S_EV_EMIT:
            begin
                emit.valid            = 1'b1;
                emit.item.kind        = KIND_WB;
                emit.item.result_page = rd_data.page;
                emit.item.result_mask = rd_data.sectors;
                emit.item.hit_count   = 3'd0;
                emit.item.last        = 1'b0;
                if (emit_ok)
                begin
                    held_next = (held_reg > HW'(ev_sz)) ? HW'(held_reg - HW'(ev_sz)) : '0;
                    cnt_next  = cnt_m1;
                    k_next    = 3'(k_reg + 3'd1);
                    need_next = (ev_sz >= need_reg) ? 3'd0 : 3'(need_reg - ev_sz);
                end
            end
            S_MISS_LOOP, S_MISS_FULL:
            begin
                ev_addr_next = cnt_m1[AW-1:0];
            end
            S_MISS_INS:
            begin
                if (cnt_reg != NW'(ENTRIES))
                begin
                    ent_next.page    = item_reg.page;
                    ent_next.sectors = req;
                    scan_next        = cnt_reg;
                    cnt_next         = NW'(cnt_reg + NW'(1));
                    held_next        = HW'(held_reg + HW'(req_cnt));
                end
            end
            S_SECT:
            begin
                scan_next = NW'(pos_reg);
                if (!s_done)
                begin
                    if (!cur_bit)
                    begin
                        sec_next = 3'(sec_reg + 3'd1);
                    end
                    else if (held_bit)
                    begin
                        sec_next  = 3'(sec_reg + 3'd1);
                        hits_next = 3'(hits_reg + 3'd1);
                    end
                    else if (can_ev_hit)
                    begin
                        // the written entry never leaves: trade places with the one before it
                        if (is_tail)
                        begin
                            ev_addr_next = cnt_m2[AW-1:0];
                            pos_next     = cnt_m2[AW-1:0];
                        end
                        else
                        begin
                            ev_addr_next = cnt_m1[AW-1:0];
                        end
                    end
                end
            end
            S_SECT_ADD:
            begin
                ent_next.sectors[sec_reg[1:0]] = 1'b1;
                held_next = HW'(held_reg + HW'(1));
                sec_next  = 3'(sec_reg + 3'd1);
                scan_next = NW'(pos_reg);
            end
            S_FINAL:
            begin
                emit.valid            = 1'b1;
                emit.item.kind        = KIND_DONE;
                emit.item.result_page = item_reg.page;
                emit.item.result_mask = rmask_reg;
                emit.item.hit_count   = hits_reg;
                emit.item.last        = 1'b1;
            end
            default:
            begin
                rd_live_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            cnt_reg     <= '0;
            held_reg    <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            cnt_reg     <= cnt_next;
            held_reg    <= held_next;
            rd_live_reg <= rd_live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        ent_reg     <= ent_next;
        pos_reg     <= pos_next;
        found_reg   <= found_next;
        scan_reg    <= scan_next;
        rd_idx_reg  <= rd_idx_next;
        ev_addr_reg <= ev_addr_next;
        k_reg       <= k_next;
        need_reg    <= need_next;
        hits_reg    <= hits_next;
        rmask_reg   <= rmask_next;
        sec_reg     <= sec_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= NW'(ENTRIES))
        else $error("entry count above depth");

    a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EV_EMIT |-> cnt_reg != '0)
        else $error("eviction from an empty buffer");

    a_evict_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EV_EMIT && emit_ok |=> cnt_reg == NW'($past(cnt_reg) - NW'(1)))
        else $error("eviction did not drop one entry");

    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINAL && emit_ok |=> state_reg == S_IDLE)
        else $error("completion beat not followed by idle");

endmodule

@@ hdl/lru_sector_write_buffer.sv @@
// Top level of the LRU sector write buffer: config register, core, result register.
//
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  lsw_pkg::in_item_t
//  rsp       out        rsp_valid/rsp_stall  lsw_pkg::out_item_t
//  cfg       in         cfg_we               cfg_data (capacity_sectors)
//
// One access at a time. Lookup walks the valid entries through the RAM read
// port; a reorder moves one entry a cycle; each write-back takes the steps
// decide, read tail and emit, and the emit step waits out any rsp stall.
// req_stall is high from acceptance until the completion beat is loaded.
// rst_n clears the entry and held sector counts and sets capacity to 256; no RAM sweep.
// The rsp register holds a beat under rsp_stall while the core waits behind it.
module lru_sector_write_buffer #(
    parameter int ENTRIES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  lsw_pkg::in_item_t  req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output lsw_pkg::out_item_t rsp,
    input  logic               cfg_we,
    input  logic [8:0]         cfg_data
);
    import lsw_pkg::*;

    logic [8:0] cap_q_reg, cap_q_next;
    logic      rsp_valid_reg, rsp_valid_next;
    out_item_t rsp_reg, rsp_next;
    logic      core_ready, emit_ok;
    emit_t     emit;

    assign req_stall = !core_ready;
    // the result register can take a beat when empty or when its beat leaves now
    assign emit_ok   = !rsp_valid_reg || !rsp_stall;

    lsw_core #(
        .ENTRIES (ENTRIES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (req_valid && core_ready),
        .item    (req),
        .cap     (cap_q_reg),
        .ready   (core_ready),
        .emit    (emit),
        .emit_ok (emit_ok)
    );

    always_comb
    begin
        cap_q_next     = cfg_we ? cfg_data : cap_q_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (emit.valid && emit_ok)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = emit.item;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_q_reg     <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cap_q_reg     <= cap_q_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
endmodule

@@ tb/tb_lru_sector_write_buffer.sv @@
// Self-checking testbench for the LRU sector write buffer.
module tb_lru_sector_write_buffer;
    import lsw_pkg::*;

    localparam int N_SLOTS = 256;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    in_item_t   req;
    logic       rsp_valid;
    logic       rsp_stall;
    out_item_t  rsp;
    logic       cfg_we;
    logic [8:0] cfg_data;

    lru_sector_write_buffer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Predictor state: LRU ranks (0 = most recent), sector bitmaps, occupancy.
    logic [31:0] lru_page [N_SLOTS];
    logic [3:0]  lru_sect [N_SLOTS];
    logic        lru_vld  [N_SLOTS];
    int unsigned lru_rank [N_SLOTS];
    int unsigned held_sectors;
    int unsigned capacity;

    out_item_t   expected_beats [$];
    int          mismatches;
    int          beats_seen;
    int          writebacks_seen;
    int          items_sent;
    longint      cycle_count;
    bit          rsp_hold_off;    // forces rsp_stall high for a stretch

    function automatic int unsigned nbits(logic [3:0] v);
        return v[0] + v[1] + v[2] + v[3];
    endfunction

    function automatic int unsigned live_entries();
        int unsigned n;
        n = 0;
        for (int i = 0; i < N_SLOTS; i++)
            if (lru_vld[i])
                n++;
        return n;
    endfunction

    function automatic int slot_of_page(logic [31:0] p);
        for (int i = 0; i < N_SLOTS; i++)
            if (lru_vld[i] && lru_page[i] == p)
                return i;
        return -1;
    endfunction

    function automatic int slot_of_rank(int unsigned r);
        for (int i = 0; i < N_SLOTS; i++)
            if (lru_vld[i] && lru_rank[i] == r)
                return i;
        return -1;
    endfunction

    function automatic void move_to_front(int idx);
        int unsigned r;
        r = lru_rank[idx];
        for (int i = 0; i < N_SLOTS; i++)
            if (lru_vld[i] && lru_rank[i] < r)
                lru_rank[i]++;
        lru_rank[idx] = 0;
    endfunction

    function automatic void queue_beat(logic kind, logic [31:0] p, logic [3:0] m,
                                       int unsigned hits, logic lst);
        out_item_t b;
        b.kind        = kind;
        b.result_page = p;
        b.result_mask = m;
        b.hit_count   = (hits > 7) ? 3'd7 : hits[2:0];
        b.last        = lst;
        expected_beats.push_back(b);
    endfunction

    // Evict the LRU tail and queue its write-back beat.
    function automatic void evict_lru_tail(ref int nwb);
        int unsigned n;
        int unsigned sz;
        int t;
        n = live_entries();
        if (n == 0)
            return;
        t = slot_of_rank(n - 1);
        if (t < 0)
            return;
        sz = nbits(lru_sect[t]);
        queue_beat(KIND_WB, lru_page[t], lru_sect[t], 0, 1'b0);
        nwb++;
        held_sectors = (held_sectors > sz) ? held_sectors - sz : 0;
        lru_vld[t] = 1'b0;
        for (int i = 0; i < N_SLOTS; i++)
            if (lru_vld[i] && lru_rank[i] > lru_rank[t])
                lru_rank[i]--;
    endfunction

    // Apply one access to the predictor and queue every beat it produces.
    function automatic void predict_access(in_item_t it);
        logic [3:0]  want;
        logic [3:0]  have;
        logic [3:0]  bit_s;
        int          idx;
        int          nwb;
        int          slot;
        int unsigned hits;
        int unsigned cnt;
        int unsigned room;
        int unsigned need;
        int unsigned sz;
        int unsigned n;
        int          pre;
        want = it.sector_mask & PAGE_BITS;
        idx  = slot_of_page(it.page);
        nwb  = 0;
        hits = 0;
        if (it.command == CMD_READ)
        begin
            have = (idx >= 0) ? lru_sect[idx] : 4'h0;
            hits = nbits(want & have);
            if (idx >= 0 && hits != 0)
                move_to_front(idx);
            queue_beat(KIND_DONE, it.page, want & ~have, hits, 1'b1);
            return;
        end
        if (want != 0 && idx < 0)
        begin
            // Write miss: make room from the tail, then insert at the front.
            cnt  = nbits(want);
            room = (capacity > held_sectors) ? capacity - held_sectors : 0;
            need = (cnt > room) ? cnt - room : 0;
            while (need > 0 && live_entries() > 0 && nwb < MAX_WRITE_BACKS)
            begin
                sz = nbits(lru_sect[slot_of_rank(live_entries() - 1)]);
                evict_lru_tail(nwb);
                need = (sz >= need) ? 0 : need - sz;
            end
            if (live_entries() >= N_SLOTS && nwb < MAX_WRITE_BACKS)
                evict_lru_tail(nwb);
            slot = -1;
            for (int i = 0; i < N_SLOTS; i++)
                if (!lru_vld[i] && slot < 0)
                    slot = i;
            if (slot >= 0)
            begin
                for (int i = 0; i < N_SLOTS; i++)
                    if (lru_vld[i])
                        lru_rank[i]++;
                lru_vld[slot]  = 1'b1;
                lru_page[slot] = it.page;
                lru_sect[slot] = want;
                lru_rank[slot] = 0;
                held_sectors  += cnt;
            end
        end
        else if (want != 0)
        begin
            // Write hit: sector by sector merge; a tail entry swaps with its
            // predecessor so it survives its own eviction.
            for (int s = 0; s < SECTORS_PER_PAGE; s++)
            begin
                bit_s = 4'(1 << s);
                if ((want & bit_s) == 0)
                    continue;
                if ((lru_sect[idx] & bit_s) != 0)
                begin
                    move_to_front(idx);
                    hits++;
                    continue;
                end
                if (held_sectors >= capacity)
                begin
                    n = live_entries();
                    if (n >= 2 && nwb < MAX_WRITE_BACKS)
                    begin
                        if (lru_rank[idx] == n - 1)
                        begin
                            pre = slot_of_rank(n - 2);
                            if (pre >= 0)
                            begin
                                lru_rank[pre] = n - 1;
                                lru_rank[idx] = n - 2;
                            end
                        end
                        evict_lru_tail(nwb);
                    end
                end
                move_to_front(idx);
                lru_sect[idx] = lru_sect[idx] | bit_s;
                held_sectors++;
            end
        end
        queue_beat(KIND_DONE, it.page, 4'h0, hits, 1'b1);
    endfunction

    // Send one access beat after a random gap; predict on acceptance.
    // With no gap the next beat follows right at the accepting edge.
    task automatic send_access(logic cmd, logic [31:0] p, logic [3:0] m);
        in_item_t it;
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.command     = cmd;
        it.page        = p;
        it.sector_mask = m;
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (req_stall);
        predict_access(it);
        items_sent++;
    endtask

    // Drop req_valid once the sender stops.
    task automatic release_req();
        if (req_valid)
            req_valid <= 1'b0;
    endtask

    // Wait for every expected beat plus slack so the core is idle.
    task automatic drain_all();
        release_req();
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic set_capacity(int unsigned cap);
        drain_all();
        cfg_we   <= 1'b1;
        cfg_data <= cap[8:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        capacity  = cap & 9'h1FF;
    endtask

    // Random page from a small pool so hits and reuse are common.
    function automatic logic [31:0] pick_page(int pool);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return 32'h8000_0000 + $urandom_range(0, pool);
        endcase
    endfunction

    task automatic random_traffic(int count, int pool);
        for (int i = 0; i < count; i++)
            send_access($urandom_range(0, 2) != 0 ? CMD_WRITE : CMD_READ,
                        pick_page(pool), 4'($urandom_range(0, 15)));
    endtask

    // Field extremes, empty masks, read of an absent page, hit and merge.
    task automatic test_directed_basics();
        send_access(CMD_READ,  32'h0000_0000, 4'hF);
        send_access(CMD_WRITE, 32'h0000_0000, 4'h0);
        send_access(CMD_WRITE, 32'h0000_0000, 4'h1);
        send_access(CMD_WRITE, 32'hFFFF_FFFF, 4'hF);
        send_access(CMD_WRITE, 32'h8000_0000, 4'hA);
        send_access(CMD_READ,  32'h8000_0000, 4'hF);
        send_access(CMD_READ,  32'h0000_0000, 4'h0);
        send_access(CMD_WRITE, 32'h0000_0000, 4'hE);
        send_access(CMD_READ,  32'hFFFF_FFFF, 4'h5);
        send_access(CMD_WRITE, 32'h8000_0000, 4'h5);
        send_access(CMD_READ,  32'h0000_0001, 4'h1);
    endtask

    // Tight capacity: tail evictions, the tail self-swap and over capacity.
    task automatic test_tail_eviction();
        set_capacity(4);
        send_access(CMD_WRITE, 32'h10, 4'h1);
        send_access(CMD_WRITE, 32'h11, 4'h1);
        send_access(CMD_WRITE, 32'h12, 4'h3);
        send_access(CMD_WRITE, 32'h10, 4'h2);  // tail of a full buffer grows
        send_access(CMD_WRITE, 32'h13, 4'hF);  // needs many write-backs
        send_access(CMD_WRITE, 32'h13, 4'hF);
        set_capacity(1);
        send_access(CMD_WRITE, 32'h13, 4'h1);  // lone entry goes over capacity
        send_access(CMD_WRITE, 32'h14, 4'hF);
        send_access(CMD_READ,  32'h14, 4'hF);
    endtask

    // Zero capacity and the full 9-bit field, taken as written.
    task automatic test_capacity_extremes();
        set_capacity(0);
        send_access(CMD_WRITE, 32'h20, 4'h3);
        send_access(CMD_WRITE, 32'h21, 4'h1);
        send_access(CMD_WRITE, 32'h21, 4'h2);
        set_capacity(511);
        random_traffic(40, 60);
    endtask

    // Several capacity settings, mostly small so evictions are frequent.
    task automatic test_random_mix();
        int unsigned caps [5] = '{256, 7, 1, 32, 13};
        foreach (caps[c])
        begin
            set_capacity(caps[c]);
            random_traffic(26, (c % 2 == 0) ? 40 : 10);
        end
    endtask

    // Many distinct pages to fill every slot and force slot-driven eviction.
    task automatic test_slot_pressure();
        set_capacity(511);
        for (int i = 0; i < 260; i++)
            send_access(CMD_WRITE, 32'h4000_0000 + i, 4'h1);
        random_traffic(15, 300);
    endtask

    // Response-side stall: random on each clock, with stall-free stretches.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (rsp_hold_off)
            rsp_stall <= 1'b1;
        else if (cycle_count % 3000 < 500)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(0, 12) < 5);
    end

    // Result checker: compare each accepted beat with the oldest expectation.
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            beats_seen++;
            if (rsp.kind == KIND_WB)
                writebacks_seen++;
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected beat %p", rsp);
            end
            else
            begin
                out_item_t want_b;
                want_b = expected_beats.pop_front();
                if (rsp.kind !== want_b.kind || rsp.result_page !== want_b.result_page
                    || rsp.result_mask !== want_b.result_mask
                    || rsp.hit_count !== want_b.hit_count || rsp.last !== want_b.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: beat mismatch exp %p got %p", want_b, rsp);
                end
            end
        end
        if (cycle_count > 3_000_000)
        begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        req_valid    = 1'b0;
        req          = '0;
        cfg_we       = 1'b0;
        cfg_data     = 9'd0;
        rsp_hold_off = 1'b0;
        rst_n        = 1'b0;
        mismatches   = 0;
        beats_seen   = 0;
        writebacks_seen = 0;
        items_sent   = 0;
        cycle_count  = 0;
        held_sectors = 0;
        capacity     = CAP_RESET;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            lru_vld[i]  = 1'b0;
            lru_sect[i] = 4'h0;
            lru_page[i] = '0;
            lru_rank[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        // Sender waits out everything; receiver holds off meanwhile, then releases.
        release_req();
        rsp_hold_off <= 1'b1;
        repeat (40) @(posedge clk);
        rsp_hold_off <= 1'b0;
        drain_all();
        test_tail_eviction();
        test_capacity_extremes();
        test_random_mix();
        test_slot_pressure();
        drain_all();

        $display("Covered %0d accesses, %0d result beats including %0d write-backs,",
                 items_sent, beats_seen, writebacks_seen);
        $display("across capacities 0 to 511 and a full set of entry slots.");
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
